// ===== design/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// wss_pkg
// Shared constants and types for the 13-point wave stencil step unit.
// ----------------------------------------------------------------------------
package wss_pkg;

   localparam int MAX_EDGE = 64;
   localparam int PAD      = 2;
   localparam int ROW_LEN  = MAX_EDGE + PAD + PAD;
   localparam int WIN      = 5;
   localparam int CNT_W    = $clog2(ROW_LEN + 1);
   localparam int ADDR_W   = $clog2(ROW_LEN);
   localparam int LINES    = 4;

   localparam logic [1:0] REG_WIDTH = 2'd0;
   localparam logic [1:0] REG_LAP   = 2'd1;
   localparam logic [1:0] REG_SRC   = 2'd2;
   localparam logic [1:0] REG_DECAY = 2'd3;

   // Stencil item handed from the front end to the arithmetic back end
   typedef struct packed {
      logic signed [31:0] card;
      logic signed [31:0] diag0;
      logic signed [31:0] diag1;
      logic signed [31:0] diag2;
      logic signed [31:0] diag3;
      logic signed [31:0] far0;
      logic signed [31:0] far1;
      logic signed [31:0] far2;
      logic signed [31:0] far3;
      logic signed [31:0] card1;
      logic signed [31:0] card2;
      logic signed [31:0] card3;
      logic signed [31:0] ctr;
      logic signed [31:0] old;
      logic [7:0]         pebble;
      logic [15:0]        decay;
      logic               last;
   } work_type;

   localparam int QDEPTH = 4;

endpackage

// ===== design/wss_ram.sv =====
// ----------------------------------------------------------------------------
// wss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/wss_front.sv =====
// ----------------------------------------------------------------------------
// wss_front
// Accepts grid cells, keeps the line buffers and window, and hands each
// completed interior cell to the queue. Each cell passes a read state, then a shift state.
// ----------------------------------------------------------------------------
module wss_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [31:0]          cur_value,
   input  logic [31:0]          old_value,
   input  logic [7:0]           pebble_size,
   input  logic [6:0]           interior_width,
   input  logic [15:0]          step_decay,
   input  logic                 width_wr,
   input  logic                 q_full,
   output logic                 q_push,
   output wss_pkg::work_type    q_data
);
   import wss_pkg::*;

   typedef enum logic [0:0] {S_TAKE, S_SHIFT} state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   col_ff, row_ff;
   logic [15:0]        decay_ff;
   logic [31:0]        win_ff [WIN*WIN];
   logic [31:0]        cur_ff, old_ff;
   logic [7:0]         peb_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [CNT_W-1:0]   p_len;
   logic [6:0]         n_eff;
   logic [31:0]        rd_data [LINES];
   logic               res_ff;
   logic               last_ff;
   logic [31:0]        decay_prod;

   always_comb begin
      n_eff = interior_width;
      if (n_eff == 7'd0) n_eff = 7'd1;
      if (n_eff > 7'(MAX_EDGE)) n_eff = 7'(MAX_EDGE);
      p_len = CNT_W'(n_eff) + CNT_W'(2*PAD);
   end

   assign in_ready   = (state_ff == S_TAKE) && !q_full;
   assign decay_prod = decay_ff * step_decay + 32'd32768;

   logic take;
   assign take = in_valid && in_ready;

   logic [ADDR_W-1:0] rd_addr;
   assign rd_addr = ADDR_W'(col_ff);

   for (genvar g = 0; g < LINES; g++) begin : g_line
      logic [31:0] wdata;
      assign wdata = (g == LINES-1) ? cur_ff : rd_data[(g == LINES-1) ? g : g+1];
      wss_ram #(.WIDTH(32), .DEPTH(ROW_LEN)) u_line (
         .clock  (clock),
         .wr_en  (state_ff == S_SHIFT),
         .wr_addr(addr_ff),
         .wr_data(wdata),
         .rd_en  (take),
         .rd_addr(rd_addr),
         .rd_data(rd_data[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TAKE;
         col_ff   <= '0;
         row_ff   <= '0;
         decay_ff <= 16'hFFFF;
         for (int i = 0; i < WIN*WIN; i++) win_ff[i] <= '0;
         res_ff   <= 1'b0;
      end else if (width_wr) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         case (state_ff)
            S_TAKE: begin
               if (take) begin
                  cur_ff  <= cur_value;
                  old_ff  <= old_value;
                  peb_ff  <= pebble_size;
                  addr_ff <= rd_addr;
                  res_ff  <= (row_ff >= CNT_W'(4)) && (col_ff >= CNT_W'(4));
                  last_ff <= (row_ff == p_len - 1'b1) && (col_ff == p_len - 1'b1);
                  if (row_ff == '0 && col_ff == '0) decay_ff <= decay_prod[31:16];
                  if (col_ff + 1'b1 >= p_len) begin
                     col_ff <= '0;
                     row_ff <= (row_ff + 1'b1 >= p_len) ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
                  state_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               for (int k = 0; k < WIN; k++) begin
                  for (int j = 0; j < WIN-1; j++) win_ff[k*WIN+j] <= win_ff[k*WIN+j+1];
                  win_ff[k*WIN+WIN-1] <= (k < LINES) ? rd_data[(k < LINES) ? k : 0] : cur_ff;
               end
               state_ff <= S_TAKE;
            end
            default: state_ff <= S_TAKE;
         endcase
      end
   end

   // Window taps after the shift: column j+1 of the old window becomes j.
   function automatic logic [31:0] tap(input int k, input int j);
      tap = (j == WIN-1) ? ((k < LINES) ? rd_data[(k < LINES) ? k : 0] : cur_ff)
                         : win_ff[k*WIN+j+1];
   endfunction

   assign q_push = (state_ff == S_SHIFT) && res_ff && !width_wr;

   always_comb begin
      q_data.card   = tap(1,2);
      q_data.card1  = tap(3,2);
      q_data.card2  = tap(2,1);
      q_data.card3  = tap(2,3);
      q_data.diag0  = tap(1,1);
      q_data.diag1  = tap(1,3);
      q_data.diag2  = tap(3,1);
      q_data.diag3  = tap(3,3);
      q_data.far0   = tap(0,2);
      q_data.far1   = tap(4,2);
      q_data.far2   = tap(2,0);
      q_data.far3   = tap(2,4);
      q_data.ctr    = tap(2,2);
      q_data.old    = old_ff;
      q_data.pebble = peb_ff;
      q_data.decay  = decay_ff;
      q_data.last   = last_ff;
   end
endmodule

// ===== design/wss_queue.sv =====
// ----------------------------------------------------------------------------
// wss_queue
// Short FIFO between stencil front end and arithmetic back end.
// ----------------------------------------------------------------------------
module wss_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wss_pkg::work_type push_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output wss_pkg::work_type pop_data
);
   import wss_pkg::*;

   localparam int PW = $clog2(QDEPTH);

   work_type       buf_ff [QDEPTH];
   logic [PW-1:0]  wp_ff, rp_ff;
   logic [PW:0]    cnt_ff;

   assign full     = (cnt_ff >= (PW+1)'(QDEPTH - 1));
   assign empty    = (cnt_ff == '0);
   assign pop_data = buf_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) buf_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end
endmodule

// ===== design/wss_back.sv =====
// ----------------------------------------------------------------------------
// wss_back
// Pipelined multiply-add: stencil sum, gain products, rounding, saturation.
// ----------------------------------------------------------------------------
module wss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   output logic              q_pop,
   input  wss_pkg::work_type q_data,
   input  logic [17:0]       lap_gain,
   input  logic [23:0]       src_gain,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,
   output logic              rsp_tlast
);
   import wss_pkg::*;

   // stage 1: stencil sum and source product part
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [39:0] s8_ff;
   logic signed [34:0] base_ff;
   logic [23:0]        pd_ff;
   logic [39:0]        src1_ff;
   logic               l1_ff, l2_ff, l3_ff, l4_ff;
   logic signed [59:0] lap_ff;
   logic [47:0]        src2_ff;
   logic signed [34:0] base2_ff;
   logic signed [61:0] acc_ff;
   logic [31:0]        out_ff;
   logic               adv;

   assign adv   = !rsp_tvalid || rsp_tready;
   // Hold pipeline entirely while the output holds a result nobody takes.
   assign q_pop = adv && !q_empty;

   logic signed [39:0] s8;
   always_comb begin
      s8 = 40'(8) * (40'(q_data.card) + 40'(q_data.card1) + 40'(q_data.card2)
           + 40'(q_data.card3))
         + 40'(2) * (40'(q_data.diag0) + 40'(q_data.diag1) + 40'(q_data.diag2)
           + 40'(q_data.diag3))
         + 40'(q_data.far0) + 40'(q_data.far1) + 40'(q_data.far2) + 40'(q_data.far3)
         - 40'(44) * 40'(q_data.ctr);
   end

   logic signed [60:0] acc_sum;
   logic signed [61:0] rnd;
   logic signed [41:0] sh;
   always_comb begin
      acc_sum = 61'(base2_ff) * 61'sd1048576 + 61'(lap_ff) - $signed({13'd0, src2_ff});
      rnd     = 62'(acc_sum) + 62'sd524288;
      sh      = 42'(acc_ff >>> 20);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s8_ff    <= s8;
         base_ff  <= 35'sd2 * 35'(q_data.ctr) - 35'(q_data.old);
         pd_ff    <= {16'd0, q_data.pebble};
         src1_ff  <= 40'(src_gain) * 40'(q_data.decay);
         l1_ff    <= q_data.last;
         lap_ff   <= 60'sd2 * $signed({42'd0, lap_gain}) * 60'(s8_ff);
         src2_ff  <= 48'(src1_ff) * 48'(pd_ff[7:0]);
         base2_ff <= base_ff;
         l2_ff    <= l1_ff;
         acc_ff   <= rnd;
         l3_ff    <= l2_ff;
         l4_ff    <= l3_ff;
         if (sh > 42'sd2147483647)       out_ff <= 32'h7FFFFFFF;
         else if (sh < -42'sd2147483648) out_ff <= 32'h80000000;
         else                            out_ff <= sh[31:0];
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = l4_ff;
endmodule

// ===== design/wave_stencil_13pt_step_unit.sv =====
// ----------------------------------------------------------------------------
// wave_stencil_13pt_step_unit
// One step of a 13-point wave stencil over a streamed padded grid.
// ----------------------------------------------------------------------------
// Usage:
//   req_*: padded grid cells in raster order, one transaction per cell; each
//     carries cur_value, plus old_value and pebble_size of the centre cell
//     that cell completes.
//   rsp_*: one transaction per completed interior cell; tlast marks the last
//     interior cell of a frame.
//   csr_*: register writes (0 width, 1 lap gain, 2 source gain, 3 decay);
//     write only while idle. Writing the width restarts the frame.
// Cell handling: a new cell is not accepted until the registered line-buffer
//   read and the write-back/window shift that needs its data are both done.
// Path: front-end read and shift, the queue, then the back-end pipeline.
// Reset clears the counters and window and sets decay to 16'hFFFF; line buffers
//   hold garbage until four rows have streamed through (pad rows precede use).
// A stalled receiver holds the back end; the short queue then fills and
//   req_tready drops until results are taken.
// ----------------------------------------------------------------------------
module wave_stencil_13pt_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cur_value, old_value, pebble_size
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // new_value
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import wss_pkg::*;

   logic [6:0]  width_ff;
   logic [17:0] lap_ff;
   logic [23:0] src_ff;
   logic [15:0] decay_ff;
   logic        wr, q_full, q_empty, q_push, q_pop;
   work_type    q_in, q_out;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 7'd64;
         lap_ff   <= 18'd16384;
         src_ff   <= '0;
         decay_ff <= 16'hFFFF;
      end else if (wr) begin
         case (csr_index)
            REG_WIDTH: width_ff <= csr_data[6:0];
            REG_LAP:   lap_ff   <= csr_data[17:0];
            REG_SRC:   src_ff   <= csr_data;
            REG_DECAY: decay_ff <= csr_data[15:0];
            default:   ;
         endcase
      end
   end

   wss_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .cur_value(req_tdata[31:0]), .old_value(req_tdata[63:32]),
      .pebble_size(req_tdata[71:64]),
      .interior_width(width_ff), .step_decay(decay_ff),
      .width_wr(wr && csr_index == REG_WIDTH),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   wss_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .full(q_full), .empty(q_empty), .pop(q_pop), .pop_data(q_out)
   );

   wss_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_pop(q_pop),
      .q_data(q_out), .lap_gain(lap_ff), .src_gain(src_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );
endmodule

// ===== design/wss_checker.sv =====
// ----------------------------------------------------------------------------
// wss_checker
// Port-level checks for the wave stencil step unit.
// ----------------------------------------------------------------------------
module wss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result right after reset");

   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("cell accepted on consecutive cycles");

   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("config port not ready");
endmodule

bind wave_stencil_13pt_step_unit wss_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_ready(csr_ready)
);
